// File: rtl/zor_pkg.sv
// Shared widths, register indexes and status codes for the z-score outlier filter.
package zor_pkg;

    // Field widths on the ports.
    localparam int SAMPLE_W   = 14;
    localparam int IN_DATA_W  = 16;
    localparam int THR_W      = 8;
    localparam int THR2_W     = 2 * THR_W;
    localparam int COUNT_W    = 4;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd1;

    // Threshold after reset: three standard deviations.
    localparam logic [THR_W-1:0] THR_RESET = 8'd48;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_PASSED   = 2'd1,
        ST_REJECTED = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

endpackage

// File: rtl/zor_mul.sv
// Shared signed multiplier with a registered product.
module zor_mul #(
    parameter int OP_W = 20
) (
    input  logic                       i_clk,
    input  logic signed [OP_W-1:0]     i_a,
    input  logic signed [OP_W-1:0]     i_b,
    output logic signed [2*OP_W-1:0]   o_prod
);

    logic signed [2*OP_W-1:0] r_prod;

    // One product per cycle, available on the next cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/zor_ring.sv
// Sample ring storage: one write port and one registered read port.
module zor_ring #(
    parameter int DEPTH = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [$clog2(DEPTH)-1:0]             i_waddr,
    input  logic signed [zor_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic [$clog2(DEPTH)-1:0]             i_raddr,
    output logic signed [zor_pkg::SAMPLE_W-1:0]  o_rdata
);

    logic signed [zor_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [zor_pkg::SAMPLE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data valid in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/zscore_outlier_reject_ring_unit.sv
// Z-score outlier filter: a sequencer around one shared multiplier and the sample ring.
// A dropped or unchecked sample is marked done on acceptance; a tested sample runs the sum,
// deviation and chunked compare states, or stops after the deviation sum when all stored
// samples are equal. One item is worked on at a time; the next request is taken in the same
// cycle as the result is offered, which waits until the result register is free.
// Reset (synchronous, active low) empties the ring, disables the filter, sets threshold 48.
module zscore_outlier_reject_ring_unit #(
    parameter int WINDOW = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Sample request.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [zor_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [13:0] sample_value
    input  logic [0:0]                        s_axis_tuser,   // [0] sample_valid
    // Result request.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [zor_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [3:0] stored_count
    output logic [1:0]                        m_axis_tuser,   // [1:0] status
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [zor_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [zor_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int PW     = LOG_W;
    localparam int CW     = $clog2(WINDOW + 1);
    localparam int FCW    = (CW > zor_pkg::COUNT_W) ? CW : zor_pkg::COUNT_W;
    localparam int SUM_W  = zor_pkg::SAMPLE_W + LOG_W;
    localparam int MAG_W  = zor_pkg::SAMPLE_W + LOG_W;
    localparam int OPW    = MAG_W + 1;
    localparam int PRD_W  = 2 * OPW;
    localparam int CHW    = MAG_W;
    localparam int QW     = 2 * MAG_W + LOG_W;
    localparam int NQ     = (QW + CHW - 1) / CHW;
    localparam int ND     = (2 * MAG_W + CHW - 1) / CHW;
    localparam int OPND_W = NQ * CHW;
    localparam int ACC_W  = OPND_W + zor_pkg::THR2_W;
    localparam int KW     = $clog2(NQ + 1);

    typedef enum logic [3:0] {
        IDLE,
        SUM_RD,
        SUM_ACC,
        Q_RD,
        Q_WX,
        Q_SUB,
        Q_SQR,
        Q_ACC,
        D_WX,
        D_SUB,
        D_SQR,
        T_SQR,
        T_CAP,
        C_MUL,
        C_ACC,
        CMP_DONE
    } t_state;

    t_state                               r_state;
    logic                                 r_done;
    logic [PW-1:0]                        r_wr_pos;
    logic [PW-1:0]                        r_idx;
    logic [FCW-1:0]                       r_fill;
    logic [FCW-1:0]                       n_fill;
    logic                                 r_en;
    logic [zor_pkg::THR_W-1:0]            r_thr;
    logic signed [zor_pkg::SAMPLE_W-1:0]  r_v;
    zor_pkg::t_status                     r_status;
    logic signed [SUM_W-1:0]              r_sum;
    logic signed [OPW-1:0]                r_e;
    logic [QW-1:0]                        r_q;
    logic [OPND_W-1:0]                    r_opnd;
    logic [KW-1:0]                        r_k;
    logic                                 r_phase;
    logic [zor_pkg::THR2_W-1:0]           r_t2;
    logic [ACC_W-1:0]                     r_acc;
    logic [ACC_W-1:0]                     n_acc;
    logic [ACC_W-1:0]                     r_lhs;
    logic                                 r_out_valid;
    zor_pkg::t_status                     r_out_status;
    logic [zor_pkg::COUNT_W-1:0]          r_out_count;

    logic                                 w_accept;
    logic                                 w_out_free;
    logic                                 w_finish;
    logic                                 w_store;
    logic signed [zor_pkg::SAMPLE_W-1:0]  w_rd_data;
    logic signed [OPW-1:0]                w_mul_a;
    logic signed [OPW-1:0]                w_mul_b;
    logic signed [PRD_W-1:0]              w_prod;

    // Handshake and result retirement.
    assign s_axis_tready = (r_state == IDLE) && !r_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_finish      = r_done && w_out_free;
    assign w_store       = w_finish &&
                           (r_status inside {zor_pkg::ST_STORED, zor_pkg::ST_PASSED});

    // Fill count after the pending sample is retired.
    always_comb begin
        n_fill = r_fill;
        if (w_store && (r_fill != FCW'(WINDOW))) begin
            n_fill = r_fill + FCW'(1);
        end
    end

    // Shift-and-add step of the chunked wide product.
    assign n_acc = (r_acc << CHW) + ACC_W'($unsigned(w_prod));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            Q_WX: begin
                w_mul_a = OPW'(w_rd_data);
                w_mul_b = OPW'(WINDOW);
            end
            D_WX: begin
                w_mul_a = OPW'(r_v);
                w_mul_b = OPW'(WINDOW);
            end
            Q_SQR, D_SQR: begin
                w_mul_a = r_e;
                w_mul_b = r_e;
            end
            T_SQR: begin
                w_mul_a = OPW'(r_thr);
                w_mul_b = OPW'(r_thr);
            end
            C_MUL: begin
                w_mul_a = OPW'(r_opnd[OPND_W-1 -: CHW]);
                w_mul_b = r_phase ? OPW'(r_t2) : OPW'(WINDOW - 1);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    zor_mul #(
        .OP_W (OPW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    zor_ring #(
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_wr_pos),
        .i_wdata (r_v),
        .i_raddr (r_idx),
        .o_rdata (w_rd_data)
    );

    // Sequencer, configuration registers, ring pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_done      <= 1'b0;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_en        <= 1'b0;
            r_thr       <= zor_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes; unknown indexes are ignored.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    zor_pkg::CFG_ENABLE:    r_en  <= i_cfg_data[0];
                    zor_pkg::CFG_THRESHOLD: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end

            // Retire the finished sample into the result register and the ring;
            // otherwise the result register drains when the consumer takes it.
            if (w_finish) begin
                r_done       <= 1'b0;
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_count  <= n_fill[zor_pkg::COUNT_W-1:0];
                r_fill       <= n_fill;
                if (w_store) begin
                    r_wr_pos <= (r_wr_pos == PW'(WINDOW - 1)) ? '0 : r_wr_pos + PW'(1);
                end
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                IDLE: begin
                    if (w_accept) begin
                        r_v <= s_axis_tdata[zor_pkg::SAMPLE_W-1:0];
                        if (!s_axis_tuser[0]) begin
                            r_status <= zor_pkg::ST_DROPPED;
                            r_done   <= 1'b1;
                        end else if (r_en && (r_fill == FCW'(WINDOW))) begin
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= SUM_RD;
                        end else begin
                            r_status <= zor_pkg::ST_STORED;
                            r_done   <= 1'b1;
                        end
                    end
                end
                // Sum of the stored samples.
                SUM_RD: begin
                    r_state <= SUM_ACC;
                end
                SUM_ACC: begin
                    r_sum <= r_sum + SUM_W'(w_rd_data);
                    if (r_idx == PW'(WINDOW - 1)) begin
                        r_idx   <= '0;
                        r_q     <= '0;
                        r_state <= Q_RD;
                    end else begin
                        r_idx   <= r_idx + PW'(1);
                        r_state <= SUM_RD;
                    end
                end
                // Sum of squared scaled deviations of the stored samples.
                Q_RD: begin
                    r_state <= Q_WX;
                end
                Q_WX: begin
                    r_state <= Q_SUB;
                end
                Q_SUB: begin
                    r_e     <= OPW'(w_prod) - OPW'(r_sum);
                    r_state <= Q_SQR;
                end
                Q_SQR: begin
                    r_state <= Q_ACC;
                end
                Q_ACC: begin
                    r_q <= r_q + QW'(w_prod[2*MAG_W-1:0]);
                    if (r_idx == PW'(WINDOW - 1)) begin
                        r_state <= D_WX;
                    end else begin
                        r_idx   <= r_idx + PW'(1);
                        r_state <= Q_RD;
                    end
                end
                // Scaled deviation of the new sample; equal samples never reject.
                D_WX: begin
                    if (r_q == '0) begin
                        r_status <= zor_pkg::ST_PASSED;
                        r_done   <= 1'b1;
                        r_state  <= IDLE;
                    end else begin
                        r_state <= D_SUB;
                    end
                end
                D_SUB: begin
                    r_e     <= OPW'(w_prod) - OPW'(r_sum);
                    r_state <= D_SQR;
                end
                D_SQR: begin
                    r_state <= T_SQR;
                end
                // Square of d goes left-aligned into the chunk register; t squared is issued.
                T_SQR: begin
                    r_opnd  <= OPND_W'(w_prod[2*MAG_W-1:0]) << (OPND_W - 2 * MAG_W);
                    r_state <= T_CAP;
                end
                T_CAP: begin
                    r_t2    <= w_prod[zor_pkg::THR2_W-1:0];
                    r_acc   <= '0;
                    r_k     <= KW'(ND);
                    r_phase <= 1'b0;
                    r_state <= C_MUL;
                end
                // Wide products one chunk at a time, most significant chunk first.
                C_MUL: begin
                    r_opnd  <= r_opnd << CHW;
                    r_k     <= r_k - KW'(1);
                    r_state <= C_ACC;
                end
                C_ACC: begin
                    if (r_k != '0) begin
                        r_acc   <= n_acc;
                        r_state <= C_MUL;
                    end else if (!r_phase) begin
                        r_lhs   <= n_acc << 8;
                        r_acc   <= '0;
                        r_opnd  <= OPND_W'(r_q);
                        r_k     <= KW'(NQ);
                        r_phase <= 1'b1;
                        r_state <= C_MUL;
                    end else begin
                        r_acc   <= n_acc;
                        r_state <= CMP_DONE;
                    end
                end
                // Reject when 256*(W-1)*d^2 exceeds t^2 times the sum of squared scaled deviations.
                CMP_DONE: begin
                    r_status <= (r_lhs > r_acc) ? zor_pkg::ST_REJECTED : zor_pkg::ST_PASSED;
                    r_done   <= 1'b1;
                    r_state  <= IDLE;
                end
                default: begin
                    r_state <= IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = zor_pkg::OUT_DATA_W'(r_out_count);

endmodule
